### hw/rtl/mrse_pkg.sv
// Shared types, constants and helpers of the mask row span extractor.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package mrse_pkg;

  localparam int MASK_WIDTH = 16;
  localparam int COL_W = $clog2(MASK_WIDTH + 1);

  localparam logic [2:0] REG_CLIP_X0   = 3'd0;
  localparam logic [2:0] REG_CLIP_Y0   = 3'd1;
  localparam logic [2:0] REG_CLIP_X1   = 3'd2;
  localparam logic [2:0] REG_CLIP_Y1   = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd5;
  localparam logic [2:0] REG_ALPHA     = 3'd6;
  localparam logic [2:0] REG_ROW_COUNT = 3'd7;

  localparam logic [7:0] DEFAULT_HEIGHT = 8'd16;

  typedef struct packed {
    logic signed [15:0] clip_x0;
    logic signed [15:0] clip_y0;
    logic signed [15:0] clip_x1;
    logic signed [15:0] clip_y1;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         alpha;
    logic [7:0]         row_count;
  } cfg_t;

  typedef struct packed {
    logic [MASK_WIDTH-1:0] row_bits;
    logic [7:0]            row_index;
  } row_t;

  typedef struct packed {
    logic signed [15:0] span_x;
    logic signed [15:0] span_y;
    logic [4:0]         span_width;
    logic               last_span;
  } span_t;

  typedef struct packed {
    logic [MASK_WIDTH-1:0] bits;
    logic signed [15:0]    ypos;
  } job_t;

  // count of clear columns ahead of the first set one, column 0 at the MSB
  function automatic logic [COL_W-1:0] lead_zeros(input logic [MASK_WIDTH-1:0] v);
    logic [COL_W-1:0] n;
    logic             found;
    n = COL_W'(MASK_WIDTH);
    found = 1'b0;
    for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = COL_W'(MASK_WIDTH - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mrse_front.sv
// Front end: accepts mask rows, applies the row tests and the column window.
// Depends on mrse_pkg.
`default_nettype none
module mrse_front (
  input  wire mrse_pkg::cfg_t cfg,
  input  wire mrse_pkg::row_t row,
  output mrse_pkg::job_t      job,
  output logic                keep
);

  logic [7:0]                      height;
  logic signed [15:0]              row_s;
  logic [mrse_pkg::MASK_WIDTH-1:0] window;
  logic signed [15:0]              col_s;
  logic                            row_ok;

  always_comb begin
    col_s = '0;
    for (int c = 0; c < mrse_pkg::MASK_WIDTH; c++) begin
      col_s = 16'(c);
      window[mrse_pkg::MASK_WIDTH-1-c] = (col_s >= cfg.clip_x0) && (col_s < cfg.clip_x1);
    end
  end

  assign height = (cfg.row_count == 8'd0) ? mrse_pkg::DEFAULT_HEIGHT : cfg.row_count;
  assign row_s  = $signed({8'd0, row.row_index});
  assign row_ok = (cfg.alpha != 8'd0) && (row.row_index < height) &&
                  (row_s >= cfg.clip_y0) && (row_s < cfg.clip_y1);

  assign job.bits = row.row_bits & window;
  assign job.ypos = cfg.origin_y + row_s;
  assign keep     = row_ok && (job.bits != '0);

endmodule
`default_nettype wire

### hw/rtl/mrse_queue.sv
// Two-entry queue of clipped rows between the front end and the span emitter.
// Depends on mrse_pkg.
`default_nettype none
module mrse_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire mrse_pkg::job_t push_job,
  output logic                full,
  input  wire                 pop,
  output logic                not_empty,
  output mrse_pkg::job_t      head
);

  mrse_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mrse_back.sv
// Span emitter: peels one run of set columns per cycle into an output register, unless span_ready holds it.
// Depends on mrse_pkg.
`default_nettype none
module mrse_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire signed [15:0]   origin_x,
  input  wire                 job_valid,
  input  wire mrse_pkg::job_t job,
  output logic                job_pop,
  output logic                span_valid,
  input  wire                 span_ready,
  output mrse_pkg::span_t     span
);

  logic [mrse_pkg::MASK_WIDTH-1:0] rem;
  logic [mrse_pkg::MASK_WIDTH-1:0] rem_next;
  logic signed [15:0]              ypos;
  logic                            busy;
  logic                            cur_valid;
  logic [mrse_pkg::MASK_WIDTH-1:0] cur_bits;
  logic signed [15:0]              cur_ypos;
  logic [mrse_pkg::MASK_WIDTH-1:0] shifted;
  logic [mrse_pkg::COL_W-1:0]      start;
  logic [mrse_pkg::COL_W-1:0]      len;
  logic [mrse_pkg::COL_W-1:0]      stop;
  logic                            advance;

  assign cur_valid = busy || job_valid;
  assign cur_bits  = busy ? rem  : job.bits;
  assign cur_ypos  = busy ? ypos : job.ypos;

  assign start    = mrse_pkg::lead_zeros(cur_bits);
  assign shifted  = cur_bits << start;
  assign len      = mrse_pkg::lead_zeros(~shifted);
  assign stop     = start + len;
  assign rem_next = cur_bits & ({mrse_pkg::MASK_WIDTH{1'b1}} >> stop);

  assign advance = cur_valid && (!span_valid || span_ready);
  assign job_pop = advance && !busy;

  always_ff @(posedge clk) begin
    if (advance) begin
      rem             <= rem_next;
      ypos            <= cur_ypos;
      span.span_x     <= origin_x + $signed(16'(start));
      span.span_y     <= cur_ypos;
      span.span_width <= 5'(len);
      span.last_span  <= (rem_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      if (advance) begin
        busy       <= (rem_next != '0);
        span_valid <= 1'b1;
      end else if (span_ready) begin
        span_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mask_row_span_extractor.sv
// Mask row span extractor: turns one 16-column mask row into clipped spans, one per cycle
// while span_ready does not hold the output. A row gives up to eight spans, with no gap
// between rows; the span emitter that peels one run per cycle sets the rate. A
// two-entry queue takes rows while spans drain; rows that give no span are dropped.
// Depends on mrse_pkg, mrse_front, mrse_queue and mrse_back.
`default_nettype none
module mask_row_span_extractor (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [2:0]           cfg_index,
  input  wire [15:0]          cfg_data,
  input  wire                 row_valid,
  output logic                row_ready,
  input  wire mrse_pkg::row_t row,
  output logic                span_valid,
  input  wire                 span_ready,
  output mrse_pkg::span_t     span
);

  mrse_pkg::cfg_t cfg;
  mrse_pkg::job_t front_job;
  mrse_pkg::job_t head;
  logic           keep;
  logic           full;
  logic           not_empty;
  logic           pop;
  logic           push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_x0   <= 16'sd0;
      cfg.clip_y0   <= 16'sd0;
      cfg.clip_x1   <= 16'sd16;
      cfg.clip_y1   <= 16'sd16;
      cfg.origin_x  <= 16'sd0;
      cfg.origin_y  <= 16'sd0;
      cfg.alpha     <= 8'd255;
      cfg.row_count <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        mrse_pkg::REG_CLIP_X0:   cfg.clip_x0   <= cfg_data;
        mrse_pkg::REG_CLIP_Y0:   cfg.clip_y0   <= cfg_data;
        mrse_pkg::REG_CLIP_X1:   cfg.clip_x1   <= cfg_data;
        mrse_pkg::REG_CLIP_Y1:   cfg.clip_y1   <= cfg_data;
        mrse_pkg::REG_ORIGIN_X:  cfg.origin_x  <= cfg_data;
        mrse_pkg::REG_ORIGIN_Y:  cfg.origin_y  <= cfg_data;
        mrse_pkg::REG_ALPHA:     cfg.alpha     <= cfg_data[7:0];
        mrse_pkg::REG_ROW_COUNT: cfg.row_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign row_ready = !full;
  assign push      = row_valid && row_ready && keep;

  mrse_front u_front (
    .cfg  (cfg),
    .row  (row),
    .job  (front_job),
    .keep (keep)
  );

  mrse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (front_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mrse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .origin_x   (cfg.origin_x),
    .job_valid  (not_empty),
    .job        (head),
    .job_pop    (pop),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span)
  );

endmodule
`default_nettype wire
